### hdl/pses_pkg.sv
// package for the prefix expression stack evaluator
// opcodes, status codes, word-size constants, a saturating conversion and shared structs; no dependencies
package pses_pkg;

  localparam int WordW = 32;
  localparam int NumVars = 6;

  typedef enum logic [2:0] {
    OP_LIT = 3'd0,
    OP_VAR = 3'd1,
    OP_ADD = 3'd2,
    OP_SUB = 3'd3,
    OP_MUL = 3'd4,
    OP_DIV = 3'd5,
    OP_END = 3'd6,
    OP_NOP = 3'd7
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_MISSING  = 3'd1,
    ST_DIVZERO  = 3'd2,
    ST_UNDEF    = 3'd3,
    ST_LEFTOVER = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_t;

  localparam logic [2:0] REG_MASK = 3'd6;

  // classified token handed from front to back
  typedef struct packed {
    opcode_t            op;
    logic [WordW-1:0]   value;
    logic               undef;
  } token_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_READ, BK_OPER, BK_MUL, BK_DIV, BK_WRITE, BK_RESULT
  } back_state_t;

  function automatic logic [WordW-1:0] sat_word(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (v > hi) sat_word = 32'h7fffffff;
    else if (v < lo) sat_word = 32'h80000000;
    else sat_word = v[WordW-1:0];
  endfunction

endpackage

### hdl/pses_if.sv
// valid/ready channel interface carrying one payload struct
// depends on nothing but the payload type given as a parameter
interface pses_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hdl/pses_in_types.sv
// payload structs for the token and result channels
// depends on nothing
package pses_io_pkg;
  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] literal_value;
    logic [2:0]         slot_index;
  } token_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [2:0]         status;
  } result_out_t;
endpackage

### hdl/pses_front.sv
// front end: accepts tokens, resolves variables, pushes into a two-entry queue
// depends on pses_pkg and pses_io_pkg
module pses_front
  import pses_pkg::*;
  import pses_io_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [WordW-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  token_in_t          in_tok,
  output logic               q_valid,
  input  logic               q_pop,
  output token_t             q_head
);
  logic [WordW-1:0] vars [NumVars];
  logic [NumVars-1:0] defined;
  token_t q [2];
  logic [1:0] q_cnt;
  logic rd_ptr, wr_ptr;
  token_t tok;
  logic push;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumVars; i++) vars[i] <= '0;
      defined <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_MASK) defined <= cfg_data[NumVars-1:0];
      else if (cfg_index < 3'(NumVars)) vars[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    tok.op = opcode_t'(in_tok.opcode);
    tok.value = in_tok.literal_value;
    tok.undef = 1'b0;
    if (tok.op == OP_VAR) begin
      if (in_tok.slot_index < 3'(NumVars) && defined[in_tok.slot_index]) begin
        tok.value = vars[in_tok.slot_index];
      end else begin
        tok.undef = 1'b1;
        tok.value = '0;
      end
    end
  end

  assign in_ready = (q_cnt != 2'd2);
  // unused opcode never reaches the back end
  assign push = in_valid && in_ready && (tok.op != OP_NOP);
  assign q_valid = (q_cnt != 2'd0);
  assign q_head = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= '0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      q_cnt <= q_cnt + 2'(push) - 2'(q_pop);
    end
  end
endmodule

### hdl/pses_back.sv
// back end: value stack memory, sticky error, arithmetic with iterative divider
// depends on pses_pkg and pses_io_pkg
module pses_back
  import pses_pkg::*;
  import pses_io_pkg::*;
#(
  parameter int StackDepth = 32,
  parameter int FracBits = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_pop,
  input  token_t      q_head,
  output logic        out_valid,
  input  logic        out_ready,
  output result_out_t out_res
);
  localparam int CntW = $clog2(StackDepth + 1);
  localparam int AddrW = $clog2(StackDepth);
  localparam int DivBits = WordW + FracBits;
  localparam int DivCntW = $clog2(DivBits + 1);

  logic [WordW-1:0] mem [StackDepth];
  logic [WordW-1:0] rd_data;
  logic [AddrW-1:0] rd_addr;
  logic [CntW-1:0] count, count_next;
  status_t sticky, sticky_next;
  back_state_t state, state_next;
  token_t cur;
  logic [WordW-1:0] first;
  logic [WordW-1:0] result;

  // multiply
  logic signed [63:0] prod;
  // divider on magnitudes
  logic [DivBits-1:0] dquo;
  logic [WordW:0] drem;
  logic [WordW-1:0] dden;
  logic dneg;
  logic [DivCntW-1:0] dcnt;
  logic [WordW:0] trial;

  logic wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [WordW-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // only an end beat has to wait for the output register to empty
  assign q_pop = (state == BK_IDLE) && q_valid && !(out_valid && q_head.op == OP_END);
  assign trial = {drem[WordW-1:0], dquo[DivBits-1]} - {1'b0, dden};

  always_comb begin
    state_next = state;
    count_next = count;
    sticky_next = sticky;
    wr_en = 1'b0;
    wr_addr = count[AddrW-1:0];
    wr_data = cur.value;
    rd_addr = AddrW'(count - CntW'(1));
    unique case (state)
      BK_IDLE: begin
        if (q_pop) begin
          if (q_head.op == OP_END) state_next = BK_RESULT;
          else if (sticky != ST_OK) state_next = BK_IDLE;
          else if (q_head.op == OP_LIT || q_head.op == OP_VAR) begin
            if (q_head.undef) sticky_next = ST_UNDEF;
            else if (count == CntW'(StackDepth)) sticky_next = ST_OVERFLOW;
            else begin
              wr_en = 1'b1;
              wr_data = q_head.value;
              count_next = count + CntW'(1);
            end
          end else if (count < CntW'(2)) sticky_next = ST_MISSING;
          else state_next = BK_READ;
        end
      end
      BK_READ: begin
        rd_addr = AddrW'(count - CntW'(2));
        state_next = BK_OPER;
      end
      BK_OPER: begin
        if (cur.op == OP_MUL) state_next = BK_MUL;
        else if (cur.op == OP_DIV) begin
          if (rd_data == '0) begin
            sticky_next = ST_DIVZERO;
            state_next = BK_IDLE;
          end else state_next = BK_DIV;
        end else state_next = BK_WRITE;
      end
      BK_MUL: state_next = BK_WRITE;
      BK_DIV: if (dcnt == DivCntW'(0)) state_next = BK_WRITE;
      BK_WRITE: begin
        wr_en = 1'b1;
        wr_addr = AddrW'(count - CntW'(2));
        wr_data = result;
        count_next = count - CntW'(1);
        state_next = BK_IDLE;
      end
      BK_RESULT: begin
        rd_addr = '0;
        count_next = '0;
        sticky_next = ST_OK;
        state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      count <= '0;
      sticky <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      sticky <= sticky_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == BK_RESULT) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_head;
    if (state == BK_READ) first <= rd_data;
    if (state == BK_RESULT) begin
      if (sticky != ST_OK) begin
        out_res.status <= sticky;
        out_res.result_value <= '0;
      end else if (count == CntW'(1)) begin
        out_res.status <= ST_OK;
        out_res.result_value <= rd_data;
      end else begin
        out_res.status <= ST_LEFTOVER;
        out_res.result_value <= '0;
      end
    end
    unique case (state)
      BK_OPER: begin
        // first is ready now, second is rd_data
        case (cur.op)
          OP_ADD: result <= sat_word(66'($signed(first)) + 66'($signed(rd_data)));
          OP_SUB: result <= sat_word(66'($signed(first)) - 66'($signed(rd_data)));
          default: result <= '0;
        endcase
        prod <= $signed(first) * $signed(rd_data);
        dneg <= first[WordW-1] ^ rd_data[WordW-1];
        dquo <= DivBits'(first[WordW-1] ? -{1'b0, first} : {1'b0, first}) << FracBits;
        dden <= rd_data[WordW-1] ? WordW'(-rd_data) : rd_data;
        drem <= '0;
        dcnt <= DivCntW'(DivBits);
      end
      BK_MUL: begin
        // round to nearest, ties up, then floor shift
        result <= sat_word(66'((prod + (FracBits > 0 ? 64'sd1 <<< (FracBits > 0 ?
                  FracBits - 1 : 0) : 64'sd0)) >>> FracBits));
      end
      BK_DIV: begin
        if (dcnt != DivCntW'(0)) begin
          if (!trial[WordW]) begin
            drem <= {1'b0, trial[WordW-1:0]};
            dquo <= {dquo[DivBits-2:0], 1'b1};
          end else begin
            drem <= {drem[WordW-1:0], dquo[DivBits-1]};
            dquo <= {dquo[DivBits-2:0], 1'b0};
          end
          dcnt <= dcnt - DivCntW'(1);
        end else begin
          result <= sat_word(dneg ? -66'($signed({1'b0, dquo})) : 66'($signed({1'b0, dquo})));
        end
      end
      default: ;
    endcase
  end
endmodule

### hdl/prefix_expression_stack_evaluator.sv
// prefix expression stack evaluator: tokens in reverse prefix order, one result per end
// channels: tokens in (opcode, literal_value, slot_index), results out (result_value,
// status); config port: cfg_we, cfg_index, cfg_data for variable slots and defined mask
// a token taken by the front is registered in the queue before the back end sees it
// a literal or variable is handled in the idle state; an unused token is dropped at the
// front; add and subtract read both operands, compute and write back; multiply adds a
// rounding state; divide makes one quotient bit a cycle over 48 bits, then applies sign
// and saturation; end leaves the result in an output register
// a two-entry token queue parts front and back so tokens are taken while work goes on
// the output register holds the result until taken; a further end waits for it
// synchronous reset clears stack count, sticky error, queue and variable registers
// stack entries hold no reset value and are only read below the count
// after the first error every token but end is ignored; end clears the stack
module prefix_expression_stack_evaluator
  import pses_pkg::*;
  import pses_io_pkg::*;
#(
  parameter int STACK_DEPTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [WordW-1:0]  cfg_data,
  pses_if.sink              tokens,
  pses_if.source            results
);
  logic q_valid, q_pop;
  token_t q_head;

  pses_front u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid (tokens.valid),
    .in_ready (tokens.ready),
    .in_tok   (tokens.payload),
    .q_valid, .q_pop, .q_head
  );

  pses_back #(.StackDepth(STACK_DEPTH), .FracBits(FRAC_BITS)) u_back (
    .clk, .rst, .q_valid, .q_pop, .q_head,
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_res   (results.payload)
  );
endmodule

### hdl/pses_checker.sv
// port-level checker for the evaluator, attached by bind
// depends on pses_pkg
module pses_checker
  import pses_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic [31:0] result_value
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result beat dropped while stalled");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> result_value == '0)
    else $error("error result carries a value");
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_OVERFLOW)
    else $error("status code out of range");
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");
endmodule

bind prefix_expression_stack_evaluator pses_checker u_checker (
  .clk, .rst,
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .status       (results.payload.status),
  .result_value (results.payload.result_value)
);
